// ===== design/imdu_pkg.sv =====
`default_nettype none
package imdu_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned RegIdxW = 5;
  localparam int unsigned OpW = 3;

  typedef enum logic [OpW-1:0] {
    OP_MUL    = 3'd0,
    OP_MULH   = 3'd1,
    OP_MULHSU = 3'd2,
    OP_MULHU  = 3'd3,
    OP_DIV    = 3'd4,
    OP_DIVU   = 3'd5,
    OP_REM    = 3'd6,
    OP_REMU   = 3'd7
  } op_e;

  // Per-item control carried down the cell row beside the data.
  typedef struct packed {
    logic               vld;
    logic               is_div;
    logic               want_rem;
    logic               want_hi;
    logic               neg_res;
    logic               by_zero;
    logic               ovf;
    logic [RegIdxW-1:0] rd;
    logic [XLEN-1:0]    a_raw;
  } ctl_t;

  // Magnitude-domain working set for one item in flight.
  // Multiply: acc holds the running 64-bit product (two's complement),
  // mcand the sign-extended multiplicand, mplier the bits left to scan.
  // Divide: acc holds the shift-subtract partial remainder and quotient.
  typedef struct packed {
    logic [2*XLEN-1:0] acc;
    logic [2*XLEN-1:0] mcand;
    logic [XLEN-1:0]   mplier;
    logic [XLEN-1:0]   dvsr;
  } work_t;

endpackage
`default_nettype wire

// ===== design/integer_multiply_divide_unit_top.sv =====
`default_nettype none
// The transaction is registered at its accepting edge, then passes through
// 32 bit-step cells, one sign-fixup stage and one output register.
// Throughput: one transaction per cycle while the row advances; every cell of the row holds its own item.
// The row advances whenever the output register is empty or being drained.
// Reset (rst_ni low, asynchronous) clears all valid flags and per-item control; work and output data are not cleared.
module integer_multiply_divide_unit_top import imdu_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [2:0] req_type, [34:3] operand_a, [66:35] operand_b,
  // [71:67] dest_index
  input  wire logic [71:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [31:0] result_value, [36:32] write_index, [37] write_enable
  output logic [39:0]      m_axis_tdata
);

  logic adv;
  logic out_vld_q;
  logic [39:0] out_q;

  assign adv = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  op_e             op;
  logic [XLEN-1:0] a, b, ma, mb;
  logic            sa, sb, na, nb;
  ctl_t            ctl0;
  work_t           work0;

  assign op = op_e'(s_axis_tdata[2:0]);
  assign a  = s_axis_tdata[34:3];
  assign b  = s_axis_tdata[66:35];

  always_comb begin
    sa = (op == OP_MULH) || (op == OP_MULHSU) || (op == OP_DIV) || (op == OP_REM);
    sb = (op == OP_MULH) || (op == OP_DIV) || (op == OP_REM);
    na = sa && a[XLEN-1];
    nb = sb && b[XLEN-1];
    ma = na ? (XLEN)'(0 - a) : a;
    mb = nb ? (XLEN)'(0 - b) : b;
    ctl0.vld      = s_axis_tvalid;
    ctl0.is_div   = s_axis_tdata[2];
    ctl0.want_rem = (op == OP_REM) || (op == OP_REMU);
    ctl0.want_hi  = (op != OP_MUL);
    ctl0.by_zero  = (b == '0);
    ctl0.ovf      = (op == OP_DIV || op == OP_REM) && (a == {1'b1, {(XLEN-1){1'b0}}})
                    && (b == '1);
    ctl0.neg_res  = ctl0.want_rem ? na : (na ^ nb);
    ctl0.rd       = s_axis_tdata[71:67];
    ctl0.a_raw    = a;
    work0 = '0;
    if (s_axis_tdata[2]) begin
      work0.acc  = {{XLEN{1'b0}}, ma};
      work0.dvsr = mb;
    end else begin
      // Multiply in two's complement: sign-extended a, b scanned LSB first.
      work0.mcand  = {{XLEN{sa & a[XLEN-1]}}, a};
      work0.mplier = b;
      work0.dvsr   = {{(XLEN-1){1'b0}}, sb};
    end
  end

  ctl_t  ctl  [XLEN+1];
  work_t work [XLEN+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl[0] <= '0;
    end else if (adv) begin
      ctl[0] <= ctl0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      work[0] <= work0;
    end
  end

  for (genvar i = 0; i < XLEN; i++) begin : g_cell
    imdu_cell #(.Step(i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .ctl_i  (ctl[i]),
      .work_i (work[i]),
      .ctl_o  (ctl[i+1]),
      .work_o (work[i+1])
    );
  end

  ctl_t            c;
  logic [XLEN-1:0] q, r, res, fix;

  assign c = ctl[XLEN];
  assign q = work[XLEN].acc[XLEN-1:0];
  assign r = work[XLEN].acc[2*XLEN-1:XLEN];

  always_comb begin
    res = c.want_rem ? r : q;
    if (c.is_div) begin
      priority if (c.by_zero) begin
        fix = c.want_rem ? c.a_raw : '1;
      end else if (c.ovf) begin
        fix = c.want_rem ? '0 : c.a_raw;
      end else begin
        fix = c.neg_res ? (XLEN)'(0 - res) : res;
      end
    end else begin
      fix = c.want_hi ? r : q;
    end
    if (c.rd == '0) begin
      fix = '0;
    end
  end

  logic fx_vld_q;
  logic [39:0] fx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      fx_vld_q  <= c.vld;
      out_vld_q <= fx_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fx_q  <= {2'b00, (c.rd != '0), c.rd, fix};
      out_q <= fx_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTH
  a_we_matches_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[37] == (m_axis_tdata[36:32] != 5'd0)))
    else $error("write enable disagrees with write index");
  a_zero_rd_zero_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[36:32] == 5'd0) |-> (m_axis_tdata[31:0] == '0))
    else $error("nonzero result for destination zero");
  a_stall_holds_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(fx_vld_q))
    else $error("pipeline moved while stalled");
`endif

endmodule
`default_nettype wire

// ===== design/imdu_cell.sv =====
`default_nettype none
module imdu_cell import imdu_pkg::*; #(
  parameter int unsigned Step = 0
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  wire ctl_t  ctl_i,
  input  wire work_t work_i,
  output ctl_t       ctl_o,
  output work_t      work_o
);

  ctl_t  ctl_q;
  work_t work_d, work_q;

  logic [XLEN:0]     trial;
  logic [XLEN:0]     rem_sh;
  logic [2*XLEN-1:0] addend;

  // For divide, acc[2*XLEN-1:XLEN] is the partial remainder and
  // acc[XLEN-1:0] the dividend bits shifting into the quotient.
  always_comb begin
    work_d = work_i;
    rem_sh = {work_i.acc[2*XLEN-1:XLEN], work_i.acc[XLEN-1]};
    trial  = rem_sh - {1'b0, work_i.dvsr};
    addend = work_i.mplier[0] ? work_i.mcand : '0;
    if (ctl_i.is_div) begin
      if (!trial[XLEN]) begin
        work_d.acc = {trial[XLEN-1:0], work_i.acc[XLEN-2:0], 1'b1};
      end else begin
        work_d.acc = {rem_sh[XLEN-1:0], work_i.acc[XLEN-2:0], 1'b0};
      end
    end else begin
      // The top multiplier bit of a signed operand has negative weight.
      if (Step == XLEN - 1 && work_i.mplier[0] && work_i.dvsr[0]) begin
        work_d.acc = work_i.acc - work_i.mcand;
      end else begin
        work_d.acc = work_i.acc + addend;
      end
      work_d.mcand  = {work_i.mcand[2*XLEN-2:0], 1'b0};
      work_d.mplier = {1'b0, work_i.mplier[XLEN-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q <= work_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign work_o = work_q;

endmodule
`default_nettype wire

// ===== tb/integer_multiply_divide_unit_top_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module integer_multiply_divide_unit_top_tb import imdu_pkg::*;;

  typedef struct packed {
    logic [31:0] result_value;
    logic [4:0]  write_index;
    logic        write_enable;
  } md_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [2:0] req_type, [34:3] operand_a, [66:35] operand_b, [71:67] dest_index
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [31:0] result_value, [36:32] write_index, [37] write_enable
  logic [39:0] m_axis_tdata;

  md_result_t pending_results[$];
  int unsigned error_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  integer_multiply_divide_unit_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

  // High half of the 64-bit product; a signed operand with its sign bit set
  // subtracts the other operand from the unsigned high half.
  function automatic logic [31:0] product_high(logic [31:0] a, logic [31:0] b,
                                               bit a_sgn, bit b_sgn);
    logic [63:0] p;
    logic [31:0] hi;
    p = {32'd0, a} * {32'd0, b};
    hi = p[63:32];
    if (a_sgn && a[31]) hi = hi - b;
    if (b_sgn && b[31]) hi = hi - a;
    return hi;
  endfunction

  function automatic md_result_t compute_muldiv(op_e op, logic [31:0] a,
                                                logic [31:0] b, logic [4:0] rd);
    md_result_t r;
    logic [31:0] ma, mb, q, m;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    case (op)
      OP_MUL:    r.result_value = a * b;
      OP_MULH:   r.result_value = product_high(a, b, 1, 1);
      OP_MULHSU: r.result_value = product_high(a, b, 1, 0);
      OP_MULHU:  r.result_value = product_high(a, b, 0, 0);
      OP_DIV, OP_REM: begin
        if (b == 0) begin
          r.result_value = (op == OP_REM) ? a : 32'hFFFF_FFFF;
        end else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
          r.result_value = (op == OP_REM) ? 32'd0 : 32'h8000_0000;
        end else begin
          q = ma / mb;
          m = ma % mb;
          if (op == OP_REM) r.result_value = a[31] ? -m : m;
          else r.result_value = (a[31] != b[31]) ? -q : q;
        end
      end
      default: begin
        if (b == 0) r.result_value = (op == OP_REMU) ? a : 32'hFFFF_FFFF;
        else r.result_value = (op == OP_REMU) ? a % b : a / b;
      end
    endcase
    if (rd == 0) r.result_value = '0;
    r.write_index = rd;
    r.write_enable = (rd != 0);
    return r;
  endfunction

  task automatic send_request(op_e op, logic [31:0] a, logic [31:0] b, logic [4:0] rd);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {rd, b, a, op};
    pending_results.push_back(compute_muldiv(op, a, b, rd));
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    end_burst();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    md_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tdata[36:32], m_axis_tdata[37]};
      if (pending_results.size() == 0) begin
        $error("unexpected result %h", got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.result_value !== want.result_value) begin
          $error("result_value expected %h actual %h", want.result_value, got.result_value);
          error_count++;
        end
        if (got.write_index !== want.write_index) begin
          $error("write_index expected %0d actual %0d", want.write_index, got.write_index);
          error_count++;
        end
        if (got.write_enable !== want.write_enable) begin
          $error("write_enable expected %0d actual %0d", want.write_enable,
                 got.write_enable);
          error_count++;
        end
      end
    end
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(15);
      5: return -$urandom_range(15);
      6: return 32'd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed_corners();
    op_e op;
    for (int i = 0; i < 8; i++) begin
      op = op_e'(i);
      send_request(op, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
      send_request(op, 32'h8000_0000, 32'h7FFF_FFFF, 5'd1);
    end
    send_request(OP_DIV, 32'h1234_5678, 32'd0, 5'd3);
    send_request(OP_DIVU, 32'h8765_4321, 32'd0, 5'd4);
    send_request(OP_REM, 32'hF000_0001, 32'd0, 5'd5);
    send_request(OP_REMU, 32'h0000_0009, 32'd0, 5'd6);
    send_request(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 5'd7);
    send_request(OP_REM, 32'h8000_0000, 32'hFFFF_FFFF, 5'd8);
    send_request(OP_MULHU, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0);
    send_request(OP_DIV, 32'hFFFF_FFF9, 32'd2, 5'd0);
    // The sender holds off here until the pipeline has fully drained.
    wait_drained();
  endtask

  task automatic test_random_ops(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_request(op_e'($urandom_range(7)), pick_operand(), pick_operand(),
                   5'($urandom_range(31)));
    end
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_corners();
    send_idle_pct = 24;
    recv_stall_pct = 62;
    test_random_ops(580);
    send_idle_pct = 62;
    recv_stall_pct = 24;
    test_random_ops(580);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_ops(580);
    repeat (40) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
